### design/wfha_pkg.sv
// ----------------------------------------------------------------------------
// wfha_pkg
// Types and constants shared by the worst-fit hole allocator.
// ----------------------------------------------------------------------------
package wfha_pkg;

    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [LEN_W-1:0]  SPLIT_MIN_RESET  = 16'd10;
    localparam logic [ADDR_W-1:0] DATA_START_RESET = 32'd0;
    localparam logic [ADDR_W-1:0] DELIM_BYTES      = 32'd1;

    // func field codes
    localparam logic FUNC_FREE  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 1'b1;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } cell_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } hole_t;

    typedef enum logic {
        ST_IDLE,
        ST_SPLIT
    } state_t;

endpackage

### design/wfha_in_if.sv
// ----------------------------------------------------------------------------
// wfha_in_if
// Request channel: free or allocate beats.
// ----------------------------------------------------------------------------
interface wfha_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] region_offset;
    logic [15:0] length;

    modport source (output valid, output func, output region_offset, output length,
                    input ready);
    modport sink   (input valid, input func, input region_offset, input length,
                    output ready);
endinterface

### design/wfha_out_if.sv
// ----------------------------------------------------------------------------
// wfha_out_if
// Result channel: one beat per request.
// ----------------------------------------------------------------------------
interface wfha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic        from_hole;
    logic        split_made;
    logic        hole_dropped;

    modport source (output valid, output address, output from_hole, output split_made,
                    output hole_dropped, input ready);
    modport sink   (input valid, input address, input from_hole, input split_made,
                    input hole_dropped, output ready);
endinterface

### design/worst_fit_hole_allocator_top.sv
// ----------------------------------------------------------------------------
// worst_fit_hole_allocator_top
// Worst-fit allocator over a length-sorted chain of free holes.
// ----------------------------------------------------------------------------
// Usage:
//   req carries free (func 0) and allocate (func 1) beats; rsp returns one
//   beat per request, in order. cfg_we/cfg_index/cfg_data write split_minimum
//   (index 0) and data_start (index 1) while the block is idle.
//   The holes live in a chain of MAX_HOLES cells kept sorted largest first;
//   a free inserts a hole into it, and an allocate that fits removes the head.
//   The result beat is registered and shows in the cycle after the request
//   beat. Throughput: one request per cycle while rsp is not stalled, except
//   that an allocate that splits a hole holds off the next request while the
//   remainder is inserted into the chain in the ST_SPLIT state.
//   A new request is taken only while the result register is empty or being
//   drained, so a stalled rsp holds off req after one beat.
//   Reset empties the chain, clears the appended byte count and restores
//   split_minimum to 10 and data_start to 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module worst_fit_hole_allocator_top
    import wfha_pkg::*;
#(
    parameter int MAX_HOLES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    wfha_in_if.sink              req,
    wfha_out_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // configuration
    logic [LEN_W-1:0]  split_min_reg;
    logic [ADDR_W-1:0] data_start_reg;

    // control
    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] appended_reg;
    logic [ADDR_W-1:0] appended_next;
    logic [ADDR_W-1:0] rest_start_reg;
    logic [LEN_W-1:0]  rest_len_reg;

    // result register
    logic              out_valid_reg;
    logic [ADDR_W-1:0] address_reg;
    logic              from_hole_reg;
    logic              split_made_reg;
    logic              dropped_reg;

    // chain
    hole_t             holes [MAX_HOLES];
    logic [MAX_HOLES-1:0] keeps;
    logic [MAX_HOLES-1:0] valid_vec;
    cell_cmd_t         cmd;

    logic              accept;
    logic              top_fits;
    logic [LEN_W-1:0]  top_spare;
    logic              split_hit;
    logic              table_full;

    assign accept     = req.valid && req.ready;
    assign top_fits   = holes[0].valid && (holes[0].length >= req.length);
    assign top_spare  = holes[0].length - req.length;
    // spare - 1 >= split_min, with spare - 1 never wrapping once spare > split_min
    assign split_hit  = top_spare > split_min_reg;
    assign table_full = holes[MAX_HOLES-1].valid;

    // ---------------- cell chain ----------------
    genvar gi;
    generate
        for (gi = 0; gi < MAX_HOLES; gi++)
        begin : g_cell
            logic  prev_keep;
            hole_t prev_hole;
            hole_t next_hole;

            if (gi == 0)
            begin : g_head
                assign prev_keep = 1'b1;
                assign prev_hole = '0;
            end
            else
            begin : g_body
                assign prev_keep = keeps[gi-1];
                assign prev_hole = holes[gi-1];
            end

            if (gi == MAX_HOLES - 1)
            begin : g_tail
                assign next_hole = '0;
            end
            else
            begin : g_link
                assign next_hole = holes[gi+1];
            end

            wfha_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .prev_keep (prev_keep),
                .prev_hole (prev_hole),
                .next_hole (next_hole),
                .hole      (holes[gi]),
                .keep      (keeps[gi])
            );

            assign valid_vec[gi] = holes[gi].valid;
        end
    endgenerate

    // ---------------- FSM ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.func == FUNC_ALLOC && top_fits && split_hit)
                    state_next = ST_SPLIT;
            end
            ST_SPLIT: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        cmd       = '{op: OP_NOP, start: req.region_offset, length: req.length};
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = !out_valid_reg || rsp.ready;
                if (accept)
                begin
                    if (req.func == FUNC_FREE)
                        cmd.op = OP_INSERT;
                    else if (top_fits)
                        cmd.op = OP_REMOVE;
                end
            end
            ST_SPLIT:
            begin
                cmd = '{op: OP_INSERT, start: rest_start_reg, length: rest_len_reg};
            end
            default: cmd.op = OP_NOP;
        endcase
    end

    always_comb
    begin
        appended_next = appended_reg;
        if (accept && req.func == FUNC_ALLOC && !top_fits)
            appended_next = appended_reg + ADDR_W'(req.length) + DELIM_BYTES;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            appended_reg   <= '0;
            split_min_reg  <= SPLIT_MIN_RESET;
            data_start_reg <= DATA_START_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            appended_reg <= appended_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SPLIT_MIN:  split_min_reg  <= cfg_data[LEN_W-1:0];
                    REG_DATA_START: data_start_reg <= cfg_data[ADDR_W-1:0];
                    default:        ;
                endcase
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload and split remainder
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rest_start_reg <= holes[0].start + ADDR_W'(req.length) + DELIM_BYTES;
            rest_len_reg   <= top_spare - LEN_W'(DELIM_BYTES);
            if (req.func == FUNC_FREE)
            begin
                address_reg    <= '0;
                from_hole_reg  <= 1'b0;
                split_made_reg <= 1'b0;
                dropped_reg    <= table_full;
            end
            else if (top_fits)
            begin
                address_reg    <= holes[0].start;
                from_hole_reg  <= 1'b1;
                split_made_reg <= split_hit;
                dropped_reg    <= 1'b0;
            end
            else
            begin
                address_reg    <= data_start_reg + appended_reg;
                from_hole_reg  <= 1'b0;
                split_made_reg <= 1'b0;
                dropped_reg    <= 1'b0;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.address      = address_reg;
    assign rsp.from_hole    = from_hole_reg;
    assign rsp.split_made   = split_made_reg;
    assign rsp.hole_dropped = dropped_reg;

    // ---------------- checks ----------------
    logic [MAX_HOLES-1:0] order_ok;

    always_comb
    begin
        order_ok[0] = 1'b1;
        for (int k = 1; k < MAX_HOLES; k++)
            order_ok[k] = !holes[k].valid || (holes[k-1].length >= holes[k].length);
    end

    // occupied cells form an unbroken run from the head
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + {{(MAX_HOLES-1){1'b0}}, 1'b1})) == '0)
        else $error("hole chain has a gap");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        &order_ok)
        else $error("hole chain out of order");

    a_split_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SPLIT |=> state_reg == ST_IDLE)
        else $error("split insert lasted more than one cycle");

    a_split_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SPLIT |-> out_valid_reg && split_made_reg)
        else $error("split pending without its result beat");

    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SPLIT |-> !table_full)
        else $error("remainder insert would drop a hole");

endmodule

### design/wfha_cell.sv
// ----------------------------------------------------------------------------
// wfha_cell
// One slot of the sorted hole chain; shifts with its neighbours.
// ----------------------------------------------------------------------------
module wfha_cell
    import wfha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  logic      prev_keep,
    input  hole_t     prev_hole,
    input  hole_t     next_hole,
    output hole_t     hole,
    output logic      keep
);

    logic              valid_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [LEN_W-1:0]  length_reg;
    hole_t             hole_next;

    assign hole = '{valid: valid_reg, start: start_reg, length: length_reg};

    // holes of equal or greater length stay ahead of the new one
    assign keep = valid_reg && (length_reg >= cmd.length);

    always_comb
    begin
        unique case (cmd.op)
            OP_INSERT:
            begin
                if (keep)
                    hole_next = hole;
                else if (prev_keep)
                    hole_next = '{valid: 1'b1, start: cmd.start, length: cmd.length};
                else
                    hole_next = prev_hole;
            end
            OP_REMOVE: hole_next = next_hole;
            default:   hole_next = hole;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= hole_next.valid;
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= hole_next.start;
        length_reg <= hole_next.length;
    end

endmodule
